@@ design/ifd_pkg.sv @@
package ifd_pkg;

  localparam logic [1:0] OP_REF     = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BEHIND  = 2'd1;
  localparam logic [1:0] ST_NOREF   = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam int REG_DATA_COLUMNS = 0;
  localparam int REG_DATA_ROWS    = 1;
  localparam int REG_REF_COLUMNS  = 2;
  localparam int REG_REF_ROWS     = 3;
  localparam int REG_SCALE_X      = 4;
  localparam int REG_SCALE_Y      = 5;
  localparam int REG_SCALE_Z      = 6;

  localparam logic signed [17:0] WEIGHT_ONE = 18'sd65536;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] sample;
    logic [31:0]        frame_time;
    logic               end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] difference;
    logic [1:0]         status;
    logic               frame_done;
    logic signed [31:0] run_min;
    logic signed [31:0] run_max;
  } out_item_t;

  typedef struct packed {
    logic [10:0] data_columns;
    logic [10:0] data_rows;
    logic [10:0] ref_columns;
    logic [10:0] ref_rows;
    logic [3:0]  scale_x;
    logic [3:0]  scale_y;
    logic [3:0]  scale_z;
  } cfg_t;

  // work passed from front to back
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] sample;
    logic [31:0]        frame_time;
    logic               end_of_frame;
    logic [9:0]         col;
    logic [9:0]         row;
    logic [15:0]        layer;
    logic               first;
  } job_t;

endpackage

@@ design/interpolated_frame_difference.sv @@
// Interpolated frame difference. Reference transactions fill the non-newest bank
// of two FRAME_WORDS-deep memories; data transactions return one result each.
// The back raises a data result through the address multiply chain, the registered
// memory read and the weighting, and takes its next transaction only once that
// result has been taken. When the two reference times differ, the first data
// transaction of a frame first runs the bit-serial weight dividers (50 quotient
// bits, then a saturation step).
// A two-entry queue parts the counter front from the arithmetic back.
module interpolated_frame_difference import ifd_pkg::*; #(
  parameter int FRAME_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_item,
  input  logic        in_valid,
  output logic        in_ready,
  output out_item_t   out_item,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic job_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{11'd1, 11'd1, 11'd1, 11'd1, 4'd1, 4'd1, 4'd1};
    end else if (psel && penable && pwrite) begin
      unique case (int'(paddr[4:2]))
        REG_DATA_COLUMNS: cfg.data_columns <= pwdata[10:0];
        REG_DATA_ROWS:    cfg.data_rows    <= pwdata[10:0];
        REG_REF_COLUMNS:  cfg.ref_columns  <= pwdata[10:0];
        REG_REF_ROWS:     cfg.ref_rows     <= pwdata[10:0];
        REG_SCALE_X:      cfg.scale_x      <= pwdata[3:0];
        REG_SCALE_Y:      cfg.scale_y      <= pwdata[3:0];
        REG_SCALE_Z:      cfg.scale_z      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (int'(paddr[4:2]))
      REG_DATA_COLUMNS: prdata = {21'd0, cfg.data_columns};
      REG_DATA_ROWS:    prdata = {21'd0, cfg.data_rows};
      REG_REF_COLUMNS:  prdata = {21'd0, cfg.ref_columns};
      REG_REF_ROWS:     prdata = {21'd0, cfg.ref_rows};
      REG_SCALE_X:      prdata = {28'd0, cfg.scale_x};
      REG_SCALE_Y:      prdata = {28'd0, cfg.scale_y};
      REG_SCALE_Z:      prdata = {28'd0, cfg.scale_z};
      default:          prdata = '0;
    endcase
  end

  ifd_front u_front (
    .clk, .rst, .cfg, .in_item, .in_valid, .in_ready,
    .job, .job_valid, .job_ready
  );

  ifd_back #(.FRAME_WORDS(FRAME_WORDS)) u_back (
    .clk, .rst, .cfg, .job, .job_valid, .job_ready,
    .out_item, .out_valid, .out_ready
  );

endmodule

@@ design/ifd_front.sv @@
module ifd_front import ifd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_ready,
  output job_t     job,
  output logic     job_valid,
  input  logic     job_ready
);

  logic [9:0]  col_count;
  logic [9:0]  row_count;
  logic [15:0] layer_count;
  logic        in_frame;
  logic [10:0] dc;
  logic [10:0] dr;
  logic [10:0] col_inc;
  logic [10:0] row_inc;
  logic        take;

  job_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign dc = (cfg.data_columns == 11'd0) ? 11'd1 :
              (cfg.data_columns > 11'd1024) ? 11'd1024 : cfg.data_columns;
  assign dr = (cfg.data_rows == 11'd0) ? 11'd1 :
              (cfg.data_rows > 11'd1024) ? 11'd1024 : cfg.data_rows;
  assign col_inc = {1'b0, col_count} + 11'd1;
  assign row_inc = {1'b0, row_count} + 11'd1;

  assign in_ready  = (cnt != 2'd2);
  assign take      = in_valid && in_ready;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (take) begin
      q[wp].operation    <= in_item.operation;
      q[wp].sample       <= in_item.sample;
      q[wp].frame_time   <= in_item.frame_time;
      q[wp].end_of_frame <= in_item.end_of_frame;
      q[wp].col          <= col_count;
      q[wp].row          <= row_count;
      q[wp].layer        <= layer_count;
      q[wp].first        <= !in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
      col_count <= '0;
      row_count <= '0;
      layer_count <= '0;
      in_frame <= 1'b0;
    end else begin
      if (take) wp <= !wp;
      if (job_valid && job_ready) rp <= !rp;
      cnt <= cnt + {1'b0, take} - {1'b0, job_valid && job_ready};
      if (take && in_item.operation == OP_RESTART) begin
        col_count <= '0;
        row_count <= '0;
        layer_count <= '0;
        in_frame <= 1'b0;
      end else if (take && in_item.operation == OP_DATA) begin
        if (in_item.end_of_frame) begin
          col_count <= '0;
          row_count <= '0;
          layer_count <= '0;
          in_frame <= 1'b0;
        end else begin
          in_frame <= 1'b1;
          if (col_inc >= dc) begin
            col_count <= '0;
            if (row_inc >= dr) begin
              row_count <= '0;
              layer_count <= layer_count + 16'd1;
            end else begin
              row_count <= row_inc[9:0];
            end
          end else begin
            col_count <= col_inc[9:0];
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    take && in_item.operation == OP_DATA && in_item.end_of_frame |=> !in_frame)
    else $error("frame not closed");
  assert property (@(posedge clk) disable iff (rst) col_count < 10'd1023 || dc == 11'd1024)
    else $error("column counter past wrap");

endmodule

@@ design/ifd_back.sv @@
module ifd_back import ifd_pkg::*; #(
  parameter int FRAME_WORDS = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  job_t      job,
  input  logic      job_valid,
  output logic      job_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int AW = $clog2(FRAME_WORDS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_ADDR1  = 4'd2;
  localparam logic [3:0] S_ADDR2  = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_WEIGHT = 4'd8;

  localparam logic signed [17:0] W_MAX = 18'sd131071;
  localparam logic signed [17:0] W_MIN = -18'sd131071 - 18'sd1;

  logic [3:0] state;

  logic signed [31:0] mem0 [FRAME_WORDS];
  logic signed [31:0] mem1 [FRAME_WORDS];
  logic signed [31:0] rd0;
  logic signed [31:0] rd1;

  logic        newest_bank;
  logic [AW:0] ref_write_pos;
  logic [1:0]  frames_loaded;
  logic [31:0] older_time;
  logic [31:0] newer_time;
  logic signed [17:0] weight_older;
  logic signed [17:0] weight_newer;
  logic signed [31:0] min_seen;
  logic signed [31:0] max_seen;

  logic [10:0] rc;
  logic [10:0] rr;
  logic [3:0]  sx;
  logic [3:0]  sy;
  logic [3:0]  sz;

  job_t        cur;
  logic [13:0] c2;
  logic [13:0] r2;
  logic [19:0] l2;
  logic [30:0] lr;
  logic [42:0] addr;
  logic [1:0]  status;
  logic signed [49:0] pa;
  logic signed [49:0] pb;
  logic signed [34:0] dsum;
  logic signed [34:0] dfull;

  // two restoring dividers sharing the divisor 2|dt|, one quotient bit a cycle
  logic signed [33:0] dt;
  logic signed [33:0] n0;
  logic signed [33:0] n1;
  logic [32:0] an0;
  logic [32:0] an1;
  logic [32:0] ad;
  logic [33:0] den;
  logic [49:0] dvd0;
  logic [49:0] dvd1;
  logic [33:0] win0;
  logic [33:0] win1;
  logic [34:0] tw0;
  logic [34:0] tw1;
  logic        ge0;
  logic        ge1;
  logic [49:0] quo0;
  logic [49:0] quo1;
  logic        neg0;
  logic        neg1;
  logic [5:0]  step;

  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic wr_bank;

  assign rc = (cfg.ref_columns == 11'd0) ? 11'd1 :
              (cfg.ref_columns > 11'd1024) ? 11'd1024 : cfg.ref_columns;
  assign rr = (cfg.ref_rows == 11'd0) ? 11'd1 :
              (cfg.ref_rows > 11'd1024) ? 11'd1024 : cfg.ref_rows;
  assign sx = (cfg.scale_x == 4'd0) ? 4'd1 : (cfg.scale_x > 4'd8) ? 4'd8 : cfg.scale_x;
  assign sy = (cfg.scale_y == 4'd0) ? 4'd1 : (cfg.scale_y > 4'd8) ? 4'd8 : cfg.scale_y;
  assign sz = (cfg.scale_z == 4'd0) ? 4'd1 : (cfg.scale_z > 4'd8) ? 4'd8 : cfg.scale_z;

  assign dt = $signed({2'b00, newer_time}) - $signed({2'b00, older_time});
  assign n0 = $signed({2'b00, newer_time}) - $signed({2'b00, job.frame_time});
  assign n1 = $signed({2'b00, job.frame_time}) - $signed({2'b00, older_time});
  assign an0 = n0[33] ? 33'(-n0) : n0[32:0];
  assign an1 = n1[33] ? 33'(-n1) : n1[32:0];
  assign ad  = dt[33] ? 33'(-dt) : dt[32:0];

  assign tw0 = {win0, dvd0[49]};
  assign tw1 = {win1, dvd1[49]};
  assign ge0 = tw0 >= {1'b0, den};
  assign ge1 = tw1 >= {1'b0, den};

  assign job_ready = (state == S_IDLE) && !out_valid;

  assign wr_en   = (state == S_IDLE) && job_valid && !out_valid &&
                   job.operation == OP_REF && ref_write_pos < (AW+1)'(FRAME_WORDS);
  assign wr_addr = ref_write_pos[AW-1:0];
  assign wr_bank = !newest_bank;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) mem0[wr_addr] <= job.sample;
    if (wr_en && wr_bank)  mem1[wr_addr] <= job.sample;
    rd0 <= mem0[addr[AW-1:0]];
    rd1 <= mem1[addr[AW-1:0]];
  end

  function automatic logic signed [17:0] sat_w(logic [49:0] q, logic neg);
    logic signed [17:0] m;
    m = $signed({1'b0, q[16:0]});
    if (q >= 50'd131072) return neg ? W_MIN : W_MAX;
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      newest_bank <= 1'b0;
      ref_write_pos <= '0;
      frames_loaded <= 2'd0;
      older_time <= '0;
      newer_time <= '0;
      weight_older <= WEIGHT_ONE;
      weight_newer <= '0;
      min_seen <= 32'sh7fffffff;
      max_seen <= 32'sh80000000;
      step <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && !out_valid) begin
            cur <= job;
            unique case (job.operation)
              OP_RESTART: begin
                newest_bank <= 1'b0;
                ref_write_pos <= '0;
                frames_loaded <= 2'd0;
                older_time <= '0;
                newer_time <= '0;
                weight_older <= WEIGHT_ONE;
                weight_newer <= '0;
                min_seen <= 32'sh7fffffff;
                max_seen <= 32'sh80000000;
              end
              OP_REF: begin
                if (wr_en) ref_write_pos <= ref_write_pos + 1'b1;
                if (job.end_of_frame) begin
                  newest_bank <= !newest_bank;
                  older_time <= newer_time;
                  newer_time <= job.frame_time;
                  if (frames_loaded != 2'd2) frames_loaded <= frames_loaded + 2'd1;
                  ref_write_pos <= '0;
                end
              end
              OP_DATA: begin
                if (job.first && dt != '0) begin
                  // dividend |num|*2^17+|dt|, divisor 2|dt|
                  dvd0 <= {an0, 17'd0} + 50'(ad);
                  dvd1 <= {an1, 17'd0} + 50'(ad);
                  den  <= {ad, 1'b0};
                  win0 <= '0;
                  win1 <= '0;
                  neg0 <= n0[33] ^ dt[33];
                  neg1 <= n1[33] ^ dt[33];
                  step <= '0;
                  state <= S_DIV;
                end else begin
                  if (job.first) begin
                    weight_older <= WEIGHT_ONE;
                    weight_newer <= '0;
                  end
                  state <= S_ADDR1;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          win0 <= ge0 ? 34'(tw0 - {1'b0, den}) : tw0[33:0];
          win1 <= ge1 ? 34'(tw1 - {1'b0, den}) : tw1[33:0];
          dvd0 <= {dvd0[48:0], 1'b0};
          dvd1 <= {dvd1[48:0], 1'b0};
          quo0 <= {quo0[48:0], ge0};
          quo1 <= {quo1[48:0], ge1};
          step <= step + 6'd1;
          if (step == 6'd49) state <= S_WEIGHT;
        end
        S_WEIGHT: begin
          weight_older <= sat_w(quo0, neg0);
          weight_newer <= sat_w(quo1, neg1);
          state <= S_ADDR1;
        end
        S_ADDR1: begin
          c2 <= 14'(sx * cur.col);
          r2 <= 14'(sy * cur.row);
          l2 <= 20'(sz * cur.layer);
          state <= S_ADDR2;
        end
        S_ADDR2: begin
          lr <= 31'(l2 * rr) + 31'(r2);
          state <= S_READ;
        end
        S_READ: begin
          addr <= 43'(lr * rc) + 43'(c2);
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          pa <= 50'(weight_older * (newest_bank ? rd0 : rd1));
          pb <= 50'(weight_newer * (newest_bank ? rd1 : rd0));
          state <= S_OUT;
        end
        S_OUT: begin
          out_item.status <= status;
          out_item.frame_done <= cur.end_of_frame;
          out_item.run_min <= (cur.sample < min_seen) ? cur.sample : min_seen;
          out_item.run_max <= (cur.sample > max_seen) ? cur.sample : max_seen;
          if (cur.sample < min_seen) min_seen <= cur.sample;
          if (cur.sample > max_seen) max_seen <= cur.sample;
          out_item.difference <= (status != ST_OK) ? 32'sd0 :
            (dfull > 35'sh0_7fffffff) ? 32'sh7fffffff :
            (dfull < -35'sh0_80000000) ? 32'sh80000000 :
            dfull[31:0];
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign dsum  = 35'((pa + pb + 50'sd32768) >>> 16);
  assign dfull = $signed({{3{cur.sample[31]}}, cur.sample}) - dsum;

  always_comb begin
    if (frames_loaded != 2'd2) status = ST_NOREF;
    else if ({3'd0, c2} >= {6'd0, rc} || {3'd0, r2} >= {6'd0, rr} ||
             addr >= 43'(FRAME_WORDS)) status = ST_RANGE;
    else if (cur.frame_time > newer_time) status = ST_BEHIND;
    else status = ST_OK;
  end

  assert property (@(posedge clk) disable iff (rst) frames_loaded != 2'd3)
    else $error("frames_loaded overflow");
  assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> out_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result changed while stalled");

endmodule
